@@ rtl/swfr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window frame receiver package
// Shared constants and types for the frame receiver: frame geometry, the
// marker bytes, result status codes and the beat types passed between the
// window and the result stage.
// ----------------------------------------------------------------------------
package swfr_pkg;

  localparam int FRAME_LEN = 56;
  localparam int NUM_WORDS = (FRAME_LEN - 2) / 4;
  localparam int FILL_W    = $clog2(FRAME_LEN + 1);
  localparam int IDX_W     = 4;

  localparam logic [7:0] HEAD_MARK = 8'hAA;
  localparam logic [7:0] TAIL_MARK = 8'h55;

  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_CSUM_ERR = 1'b1;

  typedef logic [NUM_WORDS-1:0][31:0] words_t;

  typedef struct packed {
    logic hit;
    logic csum_ok;
  } frame_evt_t;

endpackage

@@ rtl/swfr_window.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame receiver window
// Holds the last FRAME_LEN received bytes in a shift register together with
// a fill count and a running checksum, and flags head, tail and checksum
// status for the window that the accepted byte completes.
// ----------------------------------------------------------------------------
module swfr_window (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          rx_byte_i,
  output swfr_pkg::frame_evt_t evt_o,
  output swfr_pkg::words_t    words_o
);

  logic [7:0]                    win_q [swfr_pkg::FRAME_LEN];
  logic [7:0]                    win_d [swfr_pkg::FRAME_LEN];
  logic [swfr_pkg::FILL_W-1:0]   fill_q;
  logic [swfr_pkg::FILL_W-1:0]   fill_d;
  logic [7:0]                    sum_q;
  logic [7:0]                    sum_d;
  logic                          full_d;

  always_comb begin
    for (int k = 0; k < swfr_pkg::FRAME_LEN - 1; k++) begin
      win_d[k] = win_q[k+1];
    end
    win_d[swfr_pkg::FRAME_LEN-1] = rx_byte_i;
  end

  // The new sum covers the old positions 2 to FRAME_LEN-2.
  assign sum_d  = sum_q - win_q[1] + win_q[swfr_pkg::FRAME_LEN-2];
  assign fill_d = (fill_q == swfr_pkg::FILL_W'(swfr_pkg::FRAME_LEN)) ?
                  fill_q : fill_q + 1'b1;
  assign full_d = (fill_d == swfr_pkg::FILL_W'(swfr_pkg::FRAME_LEN));

  assign evt_o.hit     = accept_i && full_d && (win_q[1] == swfr_pkg::HEAD_MARK) &&
                         (rx_byte_i == swfr_pkg::TAIL_MARK);
  assign evt_o.csum_ok = (win_q[swfr_pkg::FRAME_LEN-1] == sum_d);

  always_comb begin
    for (int w = 0; w < swfr_pkg::NUM_WORDS; w++) begin
      words_o[w] = {win_d[2+4*w+3], win_d[2+4*w+2], win_d[2+4*w+1], win_d[2+4*w]};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < swfr_pkg::FRAME_LEN; k++) begin
        win_q[k] <= '0;
      end
      fill_q <= '0;
      sum_q  <= '0;
    end else if (accept_i) begin
      win_q  <= win_d;
      fill_q <= fill_d;
      sum_q  <= sum_d;
    end
  end

endmodule

@@ rtl/sliding_window_frame_receiver_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sliding window frame receiver
// Scans a byte stream for frames with a head byte, a tail byte and a
// checksum, and emits each good frame as little-endian 32-bit payload words
// or a single checksum error beat.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_stall_o   rx_byte_i
//   out      output     out_valid_o / out_stall_i word_index_o, word_value_o,
//                                                 status_o, last_o
//
// One byte is taken per cycle while the input is not stalled. A detected
// frame loads the result register at the edge that takes its tail byte and
// then drains at one beat per cycle, so without output stalls a good frame
// holds the input until its final beat leaves and a bad one not at all.
// Input is stalled only while results of an earlier frame are pending; the
// final beat can leave in the same cycle as the next byte is taken.
// Reset clears window, fill count, checksum, busy, error and index at once.
// ----------------------------------------------------------------------------
module sliding_window_frame_receiver_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  rx_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  word_index_o,
  output logic [31:0] word_value_o,
  output logic        status_o,
  output logic        last_o
);

  swfr_pkg::frame_evt_t          evt;
  swfr_pkg::words_t              words;
  swfr_pkg::words_t              pay_q;
  swfr_pkg::words_t              pay_d;
  logic                          busy_q;
  logic                          busy_d;
  logic                          err_q;
  logic                          err_d;
  logic [swfr_pkg::IDX_W-1:0]    idx_q;
  logic [swfr_pkg::IDX_W-1:0]    idx_d;
  logic                          in_acc;
  logic                          out_acc;

  assign out_acc    = busy_q && !out_stall_i;
  assign in_stall_o = busy_q && !(out_acc && last_o);
  assign in_acc     = in_valid_i && !in_stall_o;

  swfr_window u_window (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (in_acc),
    .rx_byte_i (rx_byte_i),
    .evt_o     (evt),
    .words_o   (words)
  );

  always_comb begin
    busy_d = busy_q;
    err_d  = err_q;
    idx_d  = idx_q;
    pay_d  = pay_q;
    if (out_acc) begin
      pay_d = pay_q >> 32;
      idx_d = idx_q + 1'b1;
      if (last_o) begin
        busy_d = 1'b0;
      end
    end
    if (evt.hit) begin
      busy_d = 1'b1;
      err_d  = !evt.csum_ok;
      idx_d  = '0;
      pay_d  = evt.csum_ok ? words : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      err_q  <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      err_q  <= err_d;
      idx_q  <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pay_q <= pay_d;
  end

  assign out_valid_o  = busy_q;
  assign word_index_o = idx_q;
  assign word_value_o = pay_q[0];
  assign status_o     = err_q ? swfr_pkg::STATUS_CSUM_ERR : swfr_pkg::STATUS_OK;
  assign last_o       = err_q || (idx_q == swfr_pkg::IDX_W'(swfr_pkg::NUM_WORDS - 1));

`ifndef SYNTH
  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && err_q |-> last_o && (word_index_o == '0) && (word_value_o == '0))
    else $error("Checksum error beat is malformed.");

  a_index_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && !last_o |=> out_valid_o && (word_index_o == $past(word_index_o) + 1'b1))
    else $error("Payload word index did not advance by one.");

  a_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (word_index_o <= swfr_pkg::IDX_W'(swfr_pkg::NUM_WORDS - 1)))
    else $error("Payload word index beyond the frame.");
`endif

endmodule
